### rtl/slp_pkg.sv
// shared types, codes and tables of the stepper level positioner
// no dependencies; imported by the channel interfaces and all modules
`timescale 1ns / 1ps

package slp_pkg;

   // default parameter values
   localparam int DEF_LEVEL_COUNT   = 6;
   localparam int DEF_POSITION_BITS = 10;

   // payload field widths
   localparam int OPCODE_BITS   = 2;
   localparam int LEVEL_BITS    = 3;
   localparam int COILS_BITS    = 4;
   localparam int POS_OUT_BITS  = 10;
   localparam int LED_BITS      = 3;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 12;
   localparam int STEP_CNT_BITS = 10;
   localparam int WAIT_BITS     = 12;
   localparam int CHUNK_BITS    = 6;

   typedef logic [OPCODE_BITS-1:0]   opcode_type;
   typedef logic [LEVEL_BITS-1:0]    level_type;
   typedef logic [COILS_BITS-1:0]    coils_type;
   typedef logic [POS_OUT_BITS-1:0]  pos_out_type;
   typedef logic [LED_BITS-1:0]      led_type;
   typedef logic [CSR_IDX_BITS-1:0]  csr_idx_type;
   typedef logic [CSR_DATA_BITS-1:0] csr_data_type;

   // opcodes
   localparam opcode_type OP_TICK = 2'd0;
   localparam opcode_type OP_GOTO = 2'd1;
   localparam opcode_type OP_HOME = 2'd2;

   // register indexes
   localparam csr_idx_type CSR_STEP_TICKS    = 3'd0;
   localparam csr_idx_type CSR_PAUSE_TICKS   = 3'd1;
   localparam csr_idx_type CSR_CHUNK_STEPS   = 3'd2;
   localparam csr_idx_type CSR_LEVEL_SPACING = 3'd3;
   localparam csr_idx_type CSR_HOME_STEPS    = 3'd4;
   localparam csr_idx_type CSR_BACKOFF_STEPS = 3'd5;
   localparam csr_idx_type CSR_SETTLE_TICKS  = 3'd6;

   // led colours
   localparam led_type LED_MAGENTA = 3'b101;
   localparam led_type LED_YELLOW  = 3'b110;

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_MOVE_STEP,
      MODE_MOVE_PAUSE,
      MODE_HOME_STEP,
      MODE_HOME_PAUSE,
      MODE_BACK_STEP,
      MODE_BACK_PAUSE
   } mode_type;

   // coil drive per phase: A1,A2,B1,B2
   localparam coils_type COIL_TABLE [4] = '{4'hA, 4'h6, 4'h5, 4'h9};

   // led colour per level
   localparam led_type COLOUR_TABLE [8] = '{
      3'b000, 3'b100, 3'b010, 3'b001, 3'b110, 3'b011, 3'b111, 3'b101
   };

endpackage

### rtl/slp_chan_if.sv
// valid/ready channel interfaces for command beats and result beats
// depends on slp_pkg
`timescale 1ns / 1ps

interface slp_req_if import slp_pkg::*; ();
   logic       valid;
   logic       ready;
   opcode_type opcode;
   level_type  level;

   modport source (output valid, output opcode, output level, input ready);
   modport sink   (input valid, input opcode, input level, output ready);
endinterface

interface slp_rsp_if import slp_pkg::*; ();
   logic        valid;
   logic        ready;
   coils_type   coils;
   pos_out_type position;
   led_type     led_rgb;
   logic        busy_res;
   logic        arrived;

   modport source (output valid, output coils, output position, output led_rgb,
                   output busy_res, output arrived, input ready);
   modport sink   (input valid, input coils, input position, input led_rgb,
                   input busy_res, input arrived, output ready);
endinterface

### rtl/stepper_level_positioner.sv
// stepper level positioner: full-step gauge pointer with level led
// depends on slp_pkg and the channel interfaces in slp_chan_if.sv
//
// Usage: every beat on req_chan is a tick (time step), a goto-level command or a
// home command; every accepted beat yields exactly one beat on rsp_chan carrying
// the coil drive, tracked position, led colour, busy flag and an arrival pulse.
// Commands received while a move or homing runs are dropped, but still answered.
// The result of a beat is registered and presented in the cycle after acceptance.
// Throughput: one beat per cycle; the whole state update is one pass of counter
// and compare logic between the state registers and the result register.
// When the receiver stalls, the result register holds its beat and req_chan.ready
// stays low until that beat is taken; a beat is accepted in the same cycle the
// pending result leaves. Reset (synchronous, active high) empties the result register,
// stops the motor at phase 0 and position 0, shows magenta and restores the
// register defaults. Registers are written through csr_we/csr_index/csr_wdata;
// the user must do so only while the block is idle; the block does not enforce it.
`timescale 1ns / 1ps

module stepper_level_positioner
   import slp_pkg::*;
#(
   parameter int LEVEL_COUNT   = DEF_LEVEL_COUNT,
   parameter int POSITION_BITS = DEF_POSITION_BITS
) (
   input  logic         clock,
   input  logic         reset,
   slp_req_if.sink      req_chan,
   slp_rsp_if.source    rsp_chan,
   input  logic         csr_we,
   input  csr_idx_type  csr_index,
   input  csr_data_type csr_wdata
);

   localparam int PROD_BITS = 11;
   localparam int CMP_BITS  = PROD_BITS + POSITION_BITS;
   localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
   localparam level_type LEVEL_TOP = LEVEL_BITS'(LEVEL_COUNT - 1);

   // configuration registers
   logic [7:0]               step_ticks_ff;
   logic [WAIT_BITS-1:0]     pause_ticks_ff;
   logic [CHUNK_BITS-1:0]    chunk_steps_ff;
   logic [7:0]               level_spacing_ff;
   logic [STEP_CNT_BITS-1:0] home_steps_ff;
   logic [CHUNK_BITS-1:0]    backoff_steps_ff;
   logic [WAIT_BITS-1:0]     settle_ticks_ff;

   // motion state
   logic [1:0]               phase_ff, phase_in;
   logic [POSITION_BITS-1:0] pointer_position_ff, pointer_position_in;
   logic [POSITION_BITS-1:0] target_position_ff, target_position_in;
   level_type                target_level_ff, target_level_in;
   mode_type                 mode_ff, mode_in;
   logic [WAIT_BITS-1:0]     wait_count_ff, wait_count_in;
   logic [STEP_CNT_BITS-1:0] step_count_ff, step_count_in;
   logic                     direction_ff, direction_in;
   led_type                  led_colour_ff, led_colour_in;
   logic                     arrived_in;

   // result register
   logic        rsp_valid_ff;
   coils_type   rsp_coils_ff, rsp_coils_in;
   pos_out_type rsp_position_ff, rsp_position_in;
   led_type     rsp_led_ff, rsp_led_in;
   logic        rsp_busy_ff, rsp_busy_in;
   logic        rsp_arrived_ff;

   logic                     req_fire;
   logic [CHUNK_BITS-1:0]    chunk_limit;
   logic                     move_forward;
   logic [POSITION_BITS-1:0] move_rem;
   logic [STEP_CNT_BITS-1:0] move_chunk;
   logic                     move_dir;
   logic [STEP_CNT_BITS-1:0] move_count;
   logic [CHUNK_BITS-1:0]    home_chunk;
   logic [POSITION_BITS-1:0] home_left;
   level_type                goto_level;
   level_type                levels_below;
   logic [PROD_BITS-1:0]     goto_prod;
   logic [POSITION_BITS-1:0] goto_target;

   assign req_fire      = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;

   assign chunk_limit = (chunk_steps_ff == '0) ? CHUNK_BITS'(1) : chunk_steps_ff;

   // move chunk setup
   assign move_forward = target_position_ff > pointer_position_ff;
   assign move_rem     = move_forward ? target_position_ff - pointer_position_ff
                                      : pointer_position_ff - target_position_ff;
   assign move_chunk   = (move_rem < POSITION_BITS'(chunk_limit))
                         ? STEP_CNT_BITS'(move_rem) : STEP_CNT_BITS'(chunk_limit);
   assign move_dir     = (step_count_ff == '0) ? move_forward : direction_ff;
   assign move_count   = (step_count_ff == '0) ? move_chunk : step_count_ff;

   // homing chunk setup
   assign home_chunk = (step_count_ff < STEP_CNT_BITS'(chunk_limit))
                       ? step_count_ff[CHUNK_BITS-1:0] : chunk_limit;
   assign home_left  = (target_position_ff == '0)
                       ? POSITION_BITS'(home_chunk) : target_position_ff;

   // goto target
   assign goto_level   = (req_chan.level > LEVEL_TOP) ? LEVEL_TOP : req_chan.level;
   assign levels_below = LEVEL_TOP - goto_level;
   assign goto_prod    = PROD_BITS'(level_spacing_ff) * PROD_BITS'(levels_below);
   assign goto_target  = (CMP_BITS'(goto_prod) > CMP_BITS'(POS_MAX))
                         ? POS_MAX : POSITION_BITS'(goto_prod);

   // next state
   always_comb begin
      phase_in            = phase_ff;
      pointer_position_in = pointer_position_ff;
      target_position_in  = target_position_ff;
      target_level_in     = target_level_ff;
      mode_in             = mode_ff;
      wait_count_in       = wait_count_ff;
      step_count_in       = step_count_ff;
      direction_in        = direction_ff;
      led_colour_in       = led_colour_ff;
      arrived_in          = 1'b0;
      if (req_fire) begin
         unique case (req_chan.opcode)
            OP_TICK: begin
               if (mode_ff != MODE_IDLE) begin
                  if (wait_count_ff != '0) begin
                     wait_count_in = wait_count_ff - WAIT_BITS'(1);
                  end else begin
                     unique case (mode_ff)
                        MODE_MOVE_STEP: begin
                           if (step_count_ff == '0 &&
                               pointer_position_ff == target_position_ff) begin
                              mode_in       = MODE_IDLE;
                              led_colour_in = COLOUR_TABLE[target_level_ff];
                              arrived_in    = 1'b1;
                           end else begin
                              direction_in  = move_dir;
                              phase_in      = move_dir ? phase_ff + 2'd1 : phase_ff - 2'd1;
                              wait_count_in = WAIT_BITS'(step_ticks_ff);
                              pointer_position_in = move_dir
                                 ? pointer_position_ff + POSITION_BITS'(1)
                                 : pointer_position_ff - POSITION_BITS'(1);
                              step_count_in = move_count - STEP_CNT_BITS'(1);
                              if (move_count == STEP_CNT_BITS'(1)) begin
                                 mode_in = MODE_MOVE_PAUSE;
                              end
                           end
                        end
                        MODE_MOVE_PAUSE: begin
                           wait_count_in = pause_ticks_ff;
                           mode_in       = MODE_MOVE_STEP;
                        end
                        MODE_HOME_STEP: begin
                           if (step_count_ff == '0) begin
                              wait_count_in = settle_ticks_ff;
                              step_count_in = STEP_CNT_BITS'(backoff_steps_ff);
                              mode_in       = MODE_BACK_STEP;
                           end else begin
                              phase_in           = phase_ff - 2'd1;
                              wait_count_in      = WAIT_BITS'(step_ticks_ff);
                              step_count_in      = step_count_ff - STEP_CNT_BITS'(1);
                              target_position_in = home_left - POSITION_BITS'(1);
                              if (home_left == POSITION_BITS'(1)) begin
                                 mode_in = MODE_HOME_PAUSE;
                              end
                           end
                        end
                        MODE_HOME_PAUSE: begin
                           wait_count_in = pause_ticks_ff;
                           mode_in       = MODE_HOME_STEP;
                        end
                        MODE_BACK_STEP: begin
                           if (step_count_ff == '0) begin
                              wait_count_in = pause_ticks_ff;
                              mode_in       = MODE_BACK_PAUSE;
                           end else begin
                              phase_in      = phase_ff + 2'd1;
                              wait_count_in = WAIT_BITS'(step_ticks_ff);
                              step_count_in = step_count_ff - STEP_CNT_BITS'(1);
                           end
                        end
                        MODE_BACK_PAUSE: begin
                           pointer_position_in = '0;
                           target_position_in  = '0;
                           mode_in             = MODE_IDLE;
                           arrived_in          = 1'b1;
                        end
                        default: begin
                           mode_in = MODE_IDLE;
                        end
                     endcase
                  end
               end
            end
            OP_GOTO: begin
               if (mode_ff == MODE_IDLE) begin
                  target_position_in = goto_target;
                  target_level_in    = goto_level;
                  step_count_in      = '0;
                  wait_count_in      = '0;
                  mode_in            = MODE_MOVE_STEP;
               end
            end
            OP_HOME: begin
               if (mode_ff == MODE_IDLE) begin
                  led_colour_in      = LED_YELLOW;
                  step_count_in      = home_steps_ff;
                  target_position_in = '0;
                  wait_count_in      = '0;
                  mode_in            = MODE_HOME_STEP;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // result payload
   always_comb begin
      rsp_coils_in    = COIL_TABLE[phase_in];
      rsp_position_in = POS_OUT_BITS'(pointer_position_in);
      rsp_led_in      = led_colour_in;
      rsp_busy_in     = mode_in != MODE_IDLE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff            <= '0;
         pointer_position_ff <= '0;
         target_position_ff  <= '0;
         target_level_ff     <= '0;
         mode_ff             <= MODE_IDLE;
         wait_count_ff       <= '0;
         step_count_ff       <= '0;
         direction_ff        <= 1'b0;
         led_colour_ff       <= LED_MAGENTA;
      end else begin
         phase_ff            <= phase_in;
         pointer_position_ff <= pointer_position_in;
         target_position_ff  <= target_position_in;
         target_level_ff     <= target_level_in;
         mode_ff             <= mode_in;
         wait_count_ff       <= wait_count_in;
         step_count_ff       <= step_count_in;
         direction_ff        <= direction_in;
         led_colour_ff       <= led_colour_in;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ticks_ff    <= 8'd8;
         pause_ticks_ff   <= 12'd200;
         chunk_steps_ff   <= 6'd10;
         level_spacing_ff <= 8'd70;
         home_steps_ff    <= 10'd500;
         backoff_steps_ff <= 6'd5;
         settle_ticks_ff  <= 12'd300;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_STEP_TICKS:    step_ticks_ff    <= csr_wdata[7:0];
            CSR_PAUSE_TICKS:   pause_ticks_ff   <= csr_wdata[WAIT_BITS-1:0];
            CSR_CHUNK_STEPS:   chunk_steps_ff   <= csr_wdata[CHUNK_BITS-1:0];
            CSR_LEVEL_SPACING: level_spacing_ff <= csr_wdata[7:0];
            CSR_HOME_STEPS:    home_steps_ff    <= csr_wdata[STEP_CNT_BITS-1:0];
            CSR_BACKOFF_STEPS: backoff_steps_ff <= csr_wdata[CHUNK_BITS-1:0];
            CSR_SETTLE_TICKS:  settle_ticks_ff  <= csr_wdata[WAIT_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_coils_ff    <= rsp_coils_in;
         rsp_position_ff <= rsp_position_in;
         rsp_led_ff      <= rsp_led_in;
         rsp_busy_ff     <= rsp_busy_in;
         rsp_arrived_ff  <= arrived_in;
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.coils    = rsp_coils_ff;
   assign rsp_chan.position = rsp_position_ff;
   assign rsp_chan.led_rgb  = rsp_led_ff;
   assign rsp_chan.busy_res = rsp_busy_ff;
   assign rsp_chan.arrived  = rsp_arrived_ff;

endmodule

### rtl/slp_checker.sv
// port-level assertions for the stepper level positioner
// depends on slp_pkg; bound to stepper_level_positioner below
`timescale 1ns / 1ps

module slp_checker
   import slp_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input coils_type   rsp_coils,
   input pos_out_type rsp_position,
   input led_type     rsp_led_rgb,
   input logic        rsp_busy_res,
   input logic        rsp_arrived
);

   // a stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_coils) &&
         $stable(rsp_position) && $stable(rsp_led_rgb) &&
         $stable(rsp_busy_res) && $stable(rsp_arrived))
      else $error("result beat changed while stalled");

   // every accepted beat shows a result in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted beat gave no result");

   // no beat is taken while a result is held back
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("beat accepted over a stalled result");

   // arrival ends the busy period
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_arrived |-> !rsp_busy_res)
      else $error("arrival reported while busy");

   // coil drive is always a full-step pattern
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_coils == 4'hA || rsp_coils == 4'h6 ||
         rsp_coils == 4'h5 || rsp_coils == 4'h9)
      else $error("illegal coil pattern");

endmodule

bind stepper_level_positioner slp_checker u_slp_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_coils    (rsp_chan.coils),
   .rsp_position (rsp_chan.position),
   .rsp_led_rgb  (rsp_chan.led_rgb),
   .rsp_busy_res (rsp_chan.busy_res),
   .rsp_arrived  (rsp_chan.arrived)
);
